### hdl/assert_macros.svh
// Assertion macros shared by the RTL files of the header parser.
// Each macro samples on the rising edge of clk and is disabled during reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

`define ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error(msg);

`endif

### hdl/uwhp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package uwhp_pkg;

	localparam int DEF_MAX_HEADER_BYTES = 1024;
	localparam int DATA_OFFSET_W = 11;
	localparam int CFG_INDEX_W = 8;
	localparam int CFG_DATA_W = 32;

	localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
	localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
	localparam logic [31:0] TAG_FMT = 32'h666D_7420;
	localparam logic [31:0] TAG_DATA = 32'h6461_7461;

	localparam int MIN_FILE_BYTES = 44;
	localparam logic [31:0] MIN_FMT_BYTES = 32'd16;
	localparam logic [15:0] REQ_BITS = 16'd8;
	localparam logic [15:0] REQ_CHANNELS = 16'd1;
	localparam logic [15:0] FMT_MULAW = 16'd7;

	localparam logic [CFG_INDEX_W-1:0] REG_REQUIRED_RATE = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_MIN_DATA_BYTES = CFG_INDEX_W'(1);

	localparam logic [31:0] RESET_REQUIRED_RATE = 32'd8000;
	localparam logic [15:0] RESET_MIN_DATA_BYTES = 16'd160;

	typedef enum logic [3:0] {
		PH_RIFF,
		PH_RIFFSIZE,
		PH_WAVE,
		PH_HDR,
		PH_BODY,
		PH_PAD
	} phase_t;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       last_byte;
	} item_t;

	typedef struct packed {
		logic [31:0] required_rate;
		logic [15:0] min_data_bytes;
	} cfg_t;

	typedef struct packed {
		logic                     accepted;
		logic [DATA_OFFSET_W-1:0] data_offset;
		logic [31:0]              data_length;
	} result_t;

endpackage

`default_nettype wire

### hdl/uwhp_cfg.sv
`timescale 1ns / 1ps
`default_nettype none

module uwhp_cfg (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [uwhp_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [uwhp_pkg::CFG_DATA_W-1:0]     cfg_data,
	output uwhp_pkg::cfg_t                           cfg
);

	logic [31:0] rate_q;
	logic [15:0] min_len_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q    <= uwhp_pkg::RESET_REQUIRED_RATE;
			min_len_q <= uwhp_pkg::RESET_MIN_DATA_BYTES;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				uwhp_pkg::REG_REQUIRED_RATE: begin
					rate_q <= cfg_data[31:0];
				end
				uwhp_pkg::REG_MIN_DATA_BYTES: begin
					min_len_q <= cfg_data[15:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg.required_rate  = rate_q;
	assign cfg.min_data_bytes = min_len_q;

endmodule

`default_nettype wire

### hdl/uwhp_in_reg.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module uwhp_in_reg (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] byte_value,
	input  wire logic       last_byte,
	input  wire logic       go,
	output logic            valid_s1,
	output uwhp_pkg::item_t item_s1
);

	logic            v_s1;
	uwhp_pkg::item_t data_s1;

	// The stage refills in the same cycle in which its item moves on.
	assign in_ready = !v_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			data_s1.byte_value <= byte_value;
			data_s1.last_byte  <= last_byte;
		end
	end

	assign valid_s1 = v_s1;
	assign item_s1  = data_s1;

	`ASSERT_CLK(a_stage_holds, v_s1 && !go |=> v_s1 && $stable(data_s1), "stalled item lost")

endmodule

`default_nettype wire

### hdl/uwhp_parser.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module uwhp_parser #(
	parameter int MAX_HEADER_BYTES = uwhp_pkg::DEF_MAX_HEADER_BYTES
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         step,
	input  uwhp_pkg::item_t   item,
	input  uwhp_pkg::cfg_t    cfg,
	output uwhp_pkg::result_t res
);

	localparam int PW = $clog2(MAX_HEADER_BYTES + 1);
	localparam int OffW = uwhp_pkg::DATA_OFFSET_W;
	localparam logic [PW-1:0] MaxPos = PW'(MAX_HEADER_BYTES);
	localparam logic [PW-1:0] MinFile = PW'(uwhp_pkg::MIN_FILE_BYTES);

	uwhp_pkg::phase_t phase_q, nx_phase;
	logic [PW-1:0]    pos_q, nx_pos;
	logic [31:0]      tag_q, nx_tag;
	logic [31:0]      size_q, nx_size;
	logic [31:0]      skip_q, nx_skip;
	logic [63:0]      fmt_q, nx_fmt;
	logic [15:0]      bits_q, nx_bits;
	logic [2:0]       hdr_q, nx_hdr;
	logic [4:0]       bidx_q, nx_bidx;
	logic             have_fmt_q, nx_have_fmt;
	logic             pending_q, nx_pending;
	logic             decided_q, nx_decided;
	logic [PW-1:0]    found_off_q, nx_found_off;
	logic [31:0]      found_len_q, nx_found_len;
	logic             take;
	logic             ok;

	assign take = step && !decided_q && (pos_q < MaxPos);

	always_comb begin
		logic [7:0]  b;
		logic [31:0] tag_sh;
		logic        fmt_ok;
		b      = item.byte_value;
		tag_sh = {tag_q[23:0], b};
		fmt_ok = 1'b0;

		nx_phase     = phase_q;
		nx_pos       = pos_q;
		nx_tag       = tag_q;
		nx_size      = size_q;
		nx_skip      = skip_q;
		nx_fmt       = fmt_q;
		nx_bits      = bits_q;
		nx_hdr       = hdr_q;
		nx_bidx      = bidx_q;
		nx_have_fmt  = have_fmt_q;
		nx_pending   = pending_q;
		nx_decided   = decided_q;
		nx_found_off = found_off_q;
		nx_found_len = found_len_q;

		if (take) begin
			nx_pos = pos_q + PW'(1);
			unique case (phase_q)
				uwhp_pkg::PH_RIFF: begin
					nx_tag = tag_sh;
					if (pos_q == PW'(3)) begin
						if (tag_sh != uwhp_pkg::TAG_RIFF) begin
							nx_decided = 1'b1;
							nx_pending = 1'b0;
						end else begin
							nx_phase = uwhp_pkg::PH_RIFFSIZE;
						end
					end
				end
				uwhp_pkg::PH_RIFFSIZE: begin
					if (pos_q == PW'(7)) begin
						nx_phase = uwhp_pkg::PH_WAVE;
						nx_tag   = '0;
					end
				end
				uwhp_pkg::PH_WAVE: begin
					nx_tag = tag_sh;
					if (pos_q == PW'(11)) begin
						if (tag_sh != uwhp_pkg::TAG_WAVE) begin
							nx_decided = 1'b1;
							nx_pending = 1'b0;
						end else begin
							nx_phase = uwhp_pkg::PH_HDR;
							nx_hdr   = '0;
							nx_tag   = '0;
							nx_size  = '0;
						end
					end
				end
				uwhp_pkg::PH_HDR: begin
					if (!hdr_q[2]) begin
						nx_tag = tag_sh;
					end else begin
						nx_size[{hdr_q[1:0], 3'b000} +: 8] = b;
					end
					nx_hdr = hdr_q + 3'd1;
					if (hdr_q == 3'd7) begin
						if (nx_tag == uwhp_pkg::TAG_DATA) begin
							nx_decided = 1'b1;
							if (have_fmt_q && nx_size != '0
									&& nx_size >= {16'd0, cfg.min_data_bytes}) begin
								nx_pending   = 1'b1;
								nx_found_off = nx_pos;
								nx_found_len = nx_size;
							end else begin
								nx_pending = 1'b0;
							end
						end else if (nx_tag == uwhp_pkg::TAG_FMT
								&& nx_size < uwhp_pkg::MIN_FMT_BYTES) begin
							nx_decided = 1'b1;
							nx_pending = 1'b0;
						end else begin
							nx_fmt  = '0;
							nx_bits = '0;
							nx_bidx = '0;
							nx_skip = nx_size;
							if (nx_size == '0) begin
								// An empty chunk cannot be fmt and has no pad byte.
								nx_phase = uwhp_pkg::PH_HDR;
								nx_hdr   = '0;
								nx_tag   = '0;
								nx_size  = '0;
							end else begin
								nx_phase = uwhp_pkg::PH_BODY;
							end
						end
					end
				end
				uwhp_pkg::PH_BODY: begin
					if (tag_q == uwhp_pkg::TAG_FMT) begin
						if (bidx_q[4:3] == 2'b00) begin
							nx_fmt[{bidx_q[2:0], 3'b000} +: 8] = b;
						end else if (bidx_q == 5'd14) begin
							nx_bits[7:0] = b;
						end else if (bidx_q == 5'd15) begin
							nx_bits[15:8] = b;
						end
					end
					if (bidx_q != 5'd16) begin
						nx_bidx = bidx_q + 5'd1;
					end
					nx_skip = skip_q - 32'd1;
					fmt_ok = (nx_fmt[15:0] == uwhp_pkg::FMT_MULAW)
						&& (nx_fmt[31:16] == uwhp_pkg::REQ_CHANNELS)
						&& (nx_fmt[63:32] == cfg.required_rate)
						&& (nx_bits == uwhp_pkg::REQ_BITS);
					if (nx_skip == '0) begin
						if (tag_q == uwhp_pkg::TAG_FMT && !fmt_ok) begin
							nx_decided = 1'b1;
							nx_pending = 1'b0;
						end else begin
							if (tag_q == uwhp_pkg::TAG_FMT) begin
								nx_have_fmt = 1'b1;
							end
							if (size_q[0]) begin
								nx_phase = uwhp_pkg::PH_PAD;
							end else begin
								nx_phase = uwhp_pkg::PH_HDR;
								nx_hdr   = '0;
								nx_tag   = '0;
								nx_size  = '0;
							end
						end
					end
				end
				uwhp_pkg::PH_PAD: begin
					nx_phase = uwhp_pkg::PH_HDR;
					nx_hdr   = '0;
					nx_tag   = '0;
					nx_size  = '0;
				end
				default: begin
					nx_decided = 1'b1;
					nx_pending = 1'b0;
				end
			endcase
		end
	end

	always_comb begin
		ok = nx_decided && nx_pending && (nx_pos >= MinFile);
		res.accepted    = ok;
		res.data_offset = ok ? OffW'(nx_found_off) : '0;
		res.data_length = ok ? nx_found_len : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= uwhp_pkg::PH_RIFF;
			pos_q       <= '0;
			tag_q       <= '0;
			size_q      <= '0;
			skip_q      <= '0;
			fmt_q       <= '0;
			bits_q      <= '0;
			hdr_q       <= '0;
			bidx_q      <= '0;
			have_fmt_q  <= 1'b0;
			pending_q   <= 1'b0;
			decided_q   <= 1'b0;
			found_off_q <= '0;
			found_len_q <= '0;
		end else if (step) begin
			if (item.last_byte) begin
				phase_q     <= uwhp_pkg::PH_RIFF;
				pos_q       <= '0;
				tag_q       <= '0;
				size_q      <= '0;
				skip_q      <= '0;
				fmt_q       <= '0;
				bits_q      <= '0;
				hdr_q       <= '0;
				bidx_q      <= '0;
				have_fmt_q  <= 1'b0;
				pending_q   <= 1'b0;
				decided_q   <= 1'b0;
				found_off_q <= '0;
				found_len_q <= '0;
			end else begin
				phase_q     <= nx_phase;
				pos_q       <= nx_pos;
				tag_q       <= nx_tag;
				size_q      <= nx_size;
				skip_q      <= nx_skip;
				fmt_q       <= nx_fmt;
				bits_q      <= nx_bits;
				hdr_q       <= nx_hdr;
				bidx_q      <= nx_bidx;
				have_fmt_q  <= nx_have_fmt;
				pending_q   <= nx_pending;
				decided_q   <= nx_decided;
				found_off_q <= nx_found_off;
				found_len_q <= nx_found_len;
			end
		end
	end

	`ASSERT_CLK(a_pending_decided, pending_q |-> decided_q, "verdict held before decision")
	`ASSERT_CLK(a_offset_floor, pending_q |-> found_off_q >= MinFile, "data offset too small")
	`ASSERT_CLK(a_clear_after_last, step && item.last_byte |=> pos_q == '0 && !decided_q, "parse state not cleared")

endmodule

`default_nettype wire

### hdl/ulaw_wav_header_parser.sv
// The byte marked last passes the input register; its verdict then enters the result
// register. Throughput: one header byte per cycle, the parse state being updated from
// the input register; only a last byte waits, while an untaken result is held.
// Reset: arst_n clears the parse state, the handshake stages and sets the rate and
// minimum length registers to 8000 and 160.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module ulaw_wav_header_parser #(
	parameter int MAX_HEADER_BYTES = uwhp_pkg::DEF_MAX_HEADER_BYTES
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic [7:0]                         byte_value,
	input  wire logic                               last_byte,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic                                    accepted,
	output logic [uwhp_pkg::DATA_OFFSET_W-1:0]      data_offset,
	output logic [31:0]                             data_length,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [uwhp_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire logic [uwhp_pkg::CFG_DATA_W-1:0]    cfg_data
);

	uwhp_pkg::cfg_t    cfg;
	uwhp_pkg::item_t   item_s1;
	uwhp_pkg::result_t res;
	uwhp_pkg::result_t res_s2;
	logic              valid_s1;
	logic              valid_s2;
	logic              go;

	// A byte without the last mark never needs the result register.
	assign go = valid_s1 && (!item_s1.last_byte || !valid_s2 || out_ready);

	uwhp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	uwhp_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.byte_value (byte_value),
		.last_byte  (last_byte),
		.go         (go),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1)
	);

	uwhp_parser #(
		.MAX_HEADER_BYTES (MAX_HEADER_BYTES)
	) u_parser (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (go),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (go && item_s1.last_byte) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && item_s1.last_byte) begin
			res_s2 <= res;
		end
	end

	assign out_valid   = valid_s2;
	assign accepted    = res_s2.accepted;
	assign data_offset = res_s2.data_offset;
	assign data_length = res_s2.data_length;

	`ASSERT_CLK(a_reject_zero, valid_s2 && !res_s2.accepted |-> res_s2.data_offset == '0 && res_s2.data_length == '0, "rejected result carries data")

endmodule

`default_nettype wire

### tb/tb_ulaw_wav_header_parser.sv
`timescale 1ns / 1ps

module tb_ulaw_wav_header_parser;
	import uwhp_pkg::*;

	localparam int HEADER_LIMIT = DEF_MAX_HEADER_BYTES;
	localparam int WATCHDOG_LIMIT = 3000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] byte_value = '0;
	logic last_byte = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic accepted;
	logic [DATA_OFFSET_W-1:0] data_offset;
	logic [31:0] data_length;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	ulaw_wav_header_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.byte_value(byte_value),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.accepted(accepted),
		.data_offset(data_offset),
		.data_length(data_length),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Settings as the block should hold them.
	logic [31:0] cfg_rate;
	logic [15:0] cfg_min_len;

	// Header walk state of the prediction.
	int unsigned hp_pos;
	phase_t hp_phase;
	logic [31:0] hp_tag;
	logic [31:0] hp_size;
	logic [32:0] hp_left;
	logic [63:0] hp_fmt;
	logic [15:0] hp_bits;
	logic [31:0] hp_body_idx;
	int hp_hdr_cnt;
	logic hp_have_fmt;
	logic hp_ok;
	logic hp_done;
	int unsigned hp_off;
	logic [31:0] hp_len;

	result_t expected_verdicts[$];
	result_t oldest;
	logic [7:0] file_q[$];

	int mismatches = 0;
	int bytes_sent = 0;
	int files_sent = 0;
	int verdicts_checked = 0;
	int verdicts_accepted = 0;
	int settings_written = 0;
	int idle_cycles = 0;
	int stall_left = 0;
	logic steady = 1'b0;

	task automatic note_mismatch(input string what);
		mismatches++;
		if (mismatches <= 40)
			$display("MISMATCH at %0t ns: %s", $time, what);
	endtask

	function automatic void restart_parse();
		hp_pos = 0;
		hp_phase = PH_RIFF;
		hp_tag = '0;
		hp_size = '0;
		hp_left = '0;
		hp_fmt = '0;
		hp_bits = '0;
		hp_body_idx = '0;
		hp_hdr_cnt = 0;
		hp_have_fmt = 1'b0;
		hp_ok = 1'b0;
		hp_done = 1'b0;
		hp_off = 0;
		hp_len = '0;
	endfunction

	function automatic void reject_header();
		hp_done = 1'b1;
		hp_ok = 1'b0;
	endfunction

	function automatic void open_chunk_header();
		hp_phase = PH_HDR;
		hp_hdr_cnt = 0;
		hp_tag = '0;
		hp_size = '0;
	endfunction

	function automatic void close_chunk();
		if (hp_tag == TAG_FMT) begin
			if (hp_fmt[15:0] != FMT_MULAW || hp_fmt[31:16] != REQ_CHANNELS ||
					hp_fmt[63:32] != cfg_rate || hp_bits != REQ_BITS) begin
				reject_header();
				return;
			end
			hp_have_fmt = 1'b1;
		end
		if (hp_size[0])
			hp_phase = PH_PAD;
		else
			open_chunk_header();
	endfunction

	function automatic void parse_byte(input logic [7:0] b);
		int unsigned at;
		at = hp_pos;
		hp_pos = at + 1;
		case (hp_phase)
			PH_RIFF: begin
				hp_tag = {hp_tag[23:0], b};
				if (at == 3) begin
					if (hp_tag != TAG_RIFF)
						reject_header();
					else
						hp_phase = PH_RIFFSIZE;
				end
			end
			PH_RIFFSIZE: begin
				if (at == 7) begin
					hp_phase = PH_WAVE;
					hp_tag = '0;
				end
			end
			PH_WAVE: begin
				hp_tag = {hp_tag[23:0], b};
				if (at == 11) begin
					if (hp_tag != TAG_WAVE)
						reject_header();
					else
						open_chunk_header();
				end
			end
			PH_HDR: begin
				if (hp_hdr_cnt < 4)
					hp_tag = {hp_tag[23:0], b};
				else
					hp_size[8*(hp_hdr_cnt-4) +: 8] = b;
				hp_hdr_cnt++;
				if (hp_hdr_cnt == 8) begin
					if (hp_tag == TAG_DATA) begin
						hp_done = 1'b1;
						hp_ok = hp_have_fmt && hp_size != 0 && hp_size >= {16'h0, cfg_min_len};
						if (hp_ok) begin
							hp_off = hp_pos;
							hp_len = hp_size;
						end
					end else if (hp_tag == TAG_FMT && hp_size < MIN_FMT_BYTES) begin
						reject_header();
					end else begin
						hp_fmt = '0;
						hp_bits = '0;
						hp_body_idx = '0;
						hp_left = {1'b0, hp_size};
						if (hp_left == 0)
							close_chunk();
						else
							hp_phase = PH_BODY;
					end
				end
			end
			PH_BODY: begin
				if (hp_tag == TAG_FMT) begin
					if (hp_body_idx < 8)
						hp_fmt[8*hp_body_idx +: 8] = b;
					else if (hp_body_idx == 14)
						hp_bits[7:0] = b;
					else if (hp_body_idx == 15)
						hp_bits[15:8] = b;
				end
				if (hp_body_idx != 32'hFFFF_FFFF)
					hp_body_idx++;
				hp_left--;
				if (hp_left == 0)
					close_chunk();
			end
			PH_PAD: open_chunk_header();
			default: reject_header();
		endcase
	endfunction

	function automatic void track_header_byte(input logic [7:0] b, input logic last);
		result_t verdict;
		if (!hp_done && hp_pos < HEADER_LIMIT)
			parse_byte(b);
		if (last) begin
			verdict.accepted = hp_done && hp_ok && hp_pos >= MIN_FILE_BYTES;
			verdict.data_offset = verdict.accepted ? DATA_OFFSET_W'(hp_off) : '0;
			verdict.data_length = verdict.accepted ? hp_len : '0;
			if (verdict.accepted)
				verdicts_accepted++;
			expected_verdicts.push_back(verdict);
			restart_parse();
		end
	endfunction

	function automatic int pause_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic void add_le(input logic [31:0] v, input int n);
		for (int k = 0; k < n; k++)
			file_q.push_back(v[8*k +: 8]);
	endfunction

	function automatic void add_tag(input logic [31:0] t);
		for (int k = 3; k >= 0; k--)
			file_q.push_back(t[8*k +: 8]);
	endfunction

	function automatic void add_noise(input int unsigned n);
		repeat (n)
			file_q.push_back(8'($urandom));
	endfunction

	function automatic void start_file();
		file_q.delete();
		add_tag(TAG_RIFF);
		add_le($urandom, 4);
		add_tag(TAG_WAVE);
	endfunction

	function automatic void add_junk(input int unsigned size);
		logic [31:0] t;
		t = $urandom;
		if (t == TAG_FMT || t == TAG_DATA)
			t ^= 32'h1;
		add_tag(t);
		add_le(size, 4);
		add_noise(size + size % 2);
	endfunction

	function automatic void add_fmt(input logic [31:0] rate, input logic [15:0] ftag,
			input logic [15:0] chans, input logic [15:0] bits, input logic [31:0] len);
		add_tag(TAG_FMT);
		add_le(len, 4);
		add_le(ftag, 2);
		add_le(chans, 2);
		add_le(rate, 4);
		add_le($urandom, 4);
		add_le($urandom, 2);
		add_le(bits, 2);
		if (len > MIN_FMT_BYTES)
			add_noise(len - MIN_FMT_BYTES);
		if (len[0])
			add_noise(1);
	endfunction

	function automatic void add_data(input logic [31:0] len, input int unsigned payload);
		add_tag(TAG_DATA);
		add_le(len, 4);
		add_noise(payload);
	endfunction

	function automatic void plain_wav(input logic [31:0] rate, input logic [15:0] ftag,
			input logic [15:0] chans, input logic [15:0] bits, input logic [31:0] fmt_len,
			input logic [31:0] data_len);
		start_file();
		add_fmt(rate, ftag, chans, bits, fmt_len);
		add_data(data_len, 0);
	endfunction

	function automatic void canonical(input logic [31:0] data_len);
		plain_wav(cfg_rate, FMT_MULAW, REQ_CHANNELS, REQ_BITS, MIN_FMT_BYTES, data_len);
	endfunction

	task automatic push_byte(input logic [7:0] b, input logic last);
		int gap;
		gap = steady ? 0 : pause_len();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		byte_value <= b;
		last_byte <= last;
		do @(posedge clk); while (!in_ready);
		track_header_byte(b, last);
		bytes_sent++;
	endtask

	task automatic send_file();
		for (int i = 0; i < file_q.size(); i++)
			push_byte(file_q[i], i == file_q.size() - 1);
		files_sent++;
	endtask

	task automatic reconfigure(input logic [31:0] rate, input logic [31:0] min_word);
		in_valid <= 1'b0;
		while (expected_verdicts.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= REG_REQUIRED_RATE;
		cfg_data <= rate;
		do @(posedge clk); while (!cfg_ready);
		cfg_rate = rate;
		// A write to an unused index must leave both settings alone.
		cfg_index <= CFG_INDEX_W'($urandom_range(REG_MIN_DATA_BYTES + 1, 2**CFG_INDEX_W - 1));
		cfg_data <= $urandom;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= REG_MIN_DATA_BYTES;
		cfg_data <= min_word;
		do @(posedge clk); while (!cfg_ready);
		cfg_min_len = min_word[15:0];
		cfg_valid <= 1'b0;
		settings_written++;
	endtask

	task automatic test_canonical();
		canonical(RESET_MIN_DATA_BYTES);
		send_file();
		canonical(32'hFFFF_FFFF);
		send_file();
		canonical(RESET_MIN_DATA_BYTES);
		add_noise(6);
		send_file();
	endtask

	task automatic test_bad_tags();
		canonical(200);
		file_q[3] ^= 8'h01;
		send_file();
		canonical(200);
		file_q[9] ^= 8'h20;
		send_file();
		canonical(200);
		file_q[12] ^= 8'h01;
		send_file();
		canonical(200);
		file_q[36] ^= 8'h01;
		send_file();
	endtask

	task automatic test_short_headers();
		file_q.delete();
		add_tag(TAG_RIFF);
		file_q = file_q[0:0];
		send_file();
		canonical(200);
		file_q = file_q[0:42];
		send_file();
		canonical(200);
		file_q = file_q[0:11];
		send_file();
	endtask

	task automatic test_fmt_fields();
		plain_wav(cfg_rate, ~FMT_MULAW, REQ_CHANNELS, REQ_BITS, MIN_FMT_BYTES, 200);
		send_file();
		plain_wav(cfg_rate, FMT_MULAW, REQ_CHANNELS + 16'd1, REQ_BITS, MIN_FMT_BYTES, 200);
		send_file();
		plain_wav(cfg_rate + 32'd1, FMT_MULAW, REQ_CHANNELS, REQ_BITS, MIN_FMT_BYTES, 200);
		send_file();
		plain_wav(cfg_rate, FMT_MULAW, REQ_CHANNELS, REQ_BITS << 1, MIN_FMT_BYTES, 200);
		send_file();
		plain_wav(cfg_rate, FMT_MULAW, REQ_CHANNELS, REQ_BITS, MIN_FMT_BYTES - 1, 200);
		send_file();
		plain_wav(cfg_rate, FMT_MULAW, REQ_CHANNELS, REQ_BITS, 0, 200);
		send_file();
		plain_wav(cfg_rate, FMT_MULAW, REQ_CHANNELS, REQ_BITS, MIN_FMT_BYTES + 2, 200);
		send_file();
		plain_wav(cfg_rate, FMT_MULAW, REQ_CHANNELS, REQ_BITS, MIN_FMT_BYTES + 1, 200);
		send_file();
		start_file();
		add_data(200, 0);
		add_fmt(cfg_rate, FMT_MULAW, REQ_CHANNELS, REQ_BITS, MIN_FMT_BYTES);
		send_file();
		start_file();
		add_fmt(cfg_rate, FMT_MULAW, REQ_CHANNELS, REQ_BITS, MIN_FMT_BYTES);
		add_fmt(cfg_rate, FMT_MULAW, REQ_CHANNELS, ~REQ_BITS, MIN_FMT_BYTES);
		add_data(200, 0);
		send_file();
	endtask

	task automatic test_data_length();
		canonical(0);
		send_file();
		canonical(RESET_MIN_DATA_BYTES - 1);
		send_file();
		canonical(RESET_MIN_DATA_BYTES);
		send_file();
	endtask

	task automatic test_chunk_walk();
		start_file();
		add_junk(5);
		add_fmt(cfg_rate, FMT_MULAW, REQ_CHANNELS, REQ_BITS, MIN_FMT_BYTES);
		add_junk(0);
		add_junk(2);
		add_data(RESET_MIN_DATA_BYTES, 3);
		send_file();
		// The header ends on the last body byte of an odd chunk, before its pad.
		start_file();
		add_fmt(cfg_rate, FMT_MULAW, REQ_CHANNELS, REQ_BITS, MIN_FMT_BYTES);
		add_junk(3);
		void'(file_q.pop_back());
		send_file();
		start_file();
		add_fmt(cfg_rate, FMT_MULAW, REQ_CHANNELS, REQ_BITS, MIN_FMT_BYTES);
		add_junk(3);
		send_file();
	endtask

	task automatic test_overlong();
		// The data chunk header ends at the very last position the block examines.
		start_file();
		add_fmt(cfg_rate, FMT_MULAW, REQ_CHANNELS, REQ_BITS, MIN_FMT_BYTES);
		add_junk(HEADER_LIMIT - 52);
		add_data(RESET_MIN_DATA_BYTES, 0);
		send_file();
		start_file();
		add_fmt(cfg_rate, FMT_MULAW, REQ_CHANNELS, REQ_BITS, MIN_FMT_BYTES);
		add_junk(HEADER_LIMIT - 50);
		add_data(RESET_MIN_DATA_BYTES, 0);
		send_file();
		canonical(RESET_MIN_DATA_BYTES);
		add_noise(1100);
		send_file();
		start_file();
		add_junk(1200);
		send_file();
	endtask

	task automatic test_setting_extremes();
		reconfigure(32'd1, 32'd1);
		canonical(1);
		send_file();
		canonical(0);
		send_file();
		plain_wav(RESET_REQUIRED_RATE, FMT_MULAW, REQ_CHANNELS, REQ_BITS, MIN_FMT_BYTES, 9);
		send_file();
		reconfigure(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		canonical(32'h0000_FFFF);
		send_file();
		canonical(32'h0000_FFFE);
		send_file();
		// Upper data bits are not part of the minimum, so this sets it to zero.
		reconfigure($urandom, {16'($urandom), 16'h0000});
		canonical(0);
		send_file();
		canonical(1);
		send_file();
	endtask

	task automatic run_random_files(input int byte_goal, input int file_goal);
		int first_byte, done_files, kind, cut;
		logic [31:0] rate, dlen, base, flen;
		logic [15:0] ftag, chans, bits;
		first_byte = bytes_sent;
		done_files = 0;
		while (bytes_sent - first_byte < byte_goal || done_files < file_goal) begin
			kind = $urandom_range(0, 99);
			if (kind < 5) begin
				file_q.delete();
				add_noise($urandom_range(1, 60));
			end else begin
				rate = ($urandom_range(0, 9) == 0) ? cfg_rate ^ (32'h1 << $urandom_range(0, 31))
					: cfg_rate;
				ftag = ($urandom_range(0, 9) == 0) ? 16'($urandom) : FMT_MULAW;
				chans = ($urandom_range(0, 9) == 0) ? 16'($urandom) : REQ_CHANNELS;
				bits = ($urandom_range(0, 9) == 0) ? 16'($urandom) : REQ_BITS;
				flen = ($urandom_range(0, 4) == 0) ? 32'($urandom_range(12, 21)) : MIN_FMT_BYTES;
				base = {16'h0, cfg_min_len};
				case ($urandom_range(0, 9))
					0: dlen = '0;
					1: dlen = base - 1;
					2: dlen = base;
					3, 4, 5: dlen = $urandom;
					default: dlen = base + $urandom_range(1, 1000);
				endcase
				start_file();
				if ($urandom_range(0, 49) == 0)
					add_junk($urandom_range(900, 1100));
				repeat ($urandom_range(0, 2))
					add_junk($urandom_range(0, 12));
				add_fmt(rate, ftag, chans, bits, flen);
				if ($urandom_range(0, 19) == 0)
					add_fmt($urandom, FMT_MULAW, REQ_CHANNELS, REQ_BITS, MIN_FMT_BYTES);
				repeat ($urandom_range(0, 2))
					add_junk($urandom_range(0, 12));
				add_data(dlen, $urandom_range(0, 8));
				if (kind >= 85 && kind < 92) begin
					cut = $urandom_range(0, file_q.size() - 1);
					file_q[cut] ^= 8'(1 << $urandom_range(0, 7));
				end else if (kind >= 92) begin
					cut = $urandom_range(1, file_q.size());
					file_q = file_q[0:cut-1];
				end
			end
			send_file();
			done_files++;
		end
	endtask

	task automatic test_random_traffic();
		reconfigure(RESET_REQUIRED_RATE, RESET_MIN_DATA_BYTES);
		run_random_files(360, 8);
		reconfigure(32'd1, 32'd1);
		run_random_files(360, 8);
		reconfigure(32'hFFFF_FFFF, 32'h0000_FFFF);
		run_random_files(360, 8);
		// Stretch with no idling on either side.
		steady = 1'b1;
		reconfigure($urandom, $urandom_range(1, 400));
		run_random_files(360, 8);
		steady = 1'b0;
		reconfigure($urandom, {16'($urandom), 16'h0000});
		run_random_files(360, 8);
	endtask

	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!steady && $urandom_range(0, 99) < 20) begin
			out_ready <= 1'b0;
			stall_left <= pause_len();
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_verdicts.size() == 0) begin
				note_mismatch("result transfer with no verdict outstanding");
			end else begin
				oldest = expected_verdicts.pop_front();
				verdicts_checked++;
				if (accepted !== oldest.accepted)
					note_mismatch($sformatf("accepted %b, expected %b", accepted, oldest.accepted));
				if (data_offset !== oldest.data_offset)
					note_mismatch($sformatf("data_offset %0d, expected %0d", data_offset,
						oldest.data_offset));
				if (data_length !== oldest.data_length)
					note_mismatch($sformatf("data_length %0h, expected %0h", data_length,
						oldest.data_length));
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Watchdog expired after %0d cycles without a transfer", WATCHDOG_LIMIT);
			$display("Some tests failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		cfg_rate = RESET_REQUIRED_RATE;
		cfg_min_len = RESET_MIN_DATA_BYTES;
		restart_parse();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_canonical();
		test_bad_tags();
		test_short_headers();
		test_fmt_fields();
		test_data_length();
		test_chunk_walk();
		test_overlong();
		test_setting_extremes();
		test_random_traffic();
		in_valid <= 1'b0;
		while (expected_verdicts.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		$display("Sent %0d headers (%0d bytes) across %0d register settings.",
			files_sent, bytes_sent, settings_written);
		$display("Checked %0d verdicts, %0d of them acceptances; %0d mismatches.",
			verdicts_checked, verdicts_accepted, mismatches);
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

### ulaw_wav_header_parser.f
+incdir+hdl
hdl/uwhp_pkg.sv
hdl/uwhp_cfg.sv
hdl/uwhp_in_reg.sv
hdl/uwhp_parser.sv
hdl/ulaw_wav_header_parser.sv
tb/tb_ulaw_wav_header_parser.sv
